[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the decoder checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/utf8d_pkg.sv]
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared types and constants of the utf-8 stream decoder
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CP_W        = 21;
    localparam int unsigned CP_PAD_W    = 24;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // one queue entry: replacements first, then an optional final code point
    typedef struct packed {
        logic [1:0]      rep_cnt;
        logic            has_tail;
        logic [CP_W-1:0] tail_cp;
    } desc_t;

endpackage

[rtl/core/utf8_stream_decoder_top.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// utf-8 byte stream to code point stream with u+fffd replacement
// ----------------------------------------------------------------------------
// takes one utf-8 byte per transaction (s_tlast marks the final byte of the
// text) and returns 21-bit code points; a byte that only opens or extends a
// sequence returns nothing, a malformed sequence returns one u+fffd for the
// lead and one per continuation already gathered, followed by the results of
// the byte that broke it; m_tlast marks the final result caused by each input
// byte. there are no overlong, surrogate or range checks. the front accepts
// one byte per cycle as long as the descriptor queue (QueueDepth entries) has
// room; the back emits one result per cycle while m_tready is high, so a byte
// that causes k results (k is at most 4) holds the back until all k are sent,
// and sustained input slows only while malformed bursts or receiver stalls keep
// the queue full. a descriptor is registered in the queue, then in the back.
module utf8_stream_decoder_top
    import utf8d_pkg::*;
#(
    parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,   // [7:0] text_byte
    input  logic                s_tlast,   // end_of_text
    // result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [CP_PAD_W-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic                m_tlast    // last_of_run
);

    // front to queue
    logic  push_valid, push_ready;
    desc_t push_desc;

    // queue to back
    logic  q_valid, q_ready;
    desc_t q_desc;

    // classify bytes and track the open sequence
    utf8d_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    // decouples byte intake from result emission
    utf8d_queue #(
        .DEPTH (QueueDepth)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_desc   (push_desc),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_desc  (q_desc)
    );

    // one result transaction per cycle while m_tready is high, replacements first
    utf8d_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_desc   (q_desc),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/core/utf8d_queue.sv]
// ----------------------------------------------------------------------------
// utf8d_queue
// small register fifo of result descriptors between front and back
// ----------------------------------------------------------------------------
module utf8d_queue
    import utf8d_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  desc_t in_desc,
    output logic  out_valid,
    input  logic  out_ready,
    output desc_t out_desc
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    desc_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_desc  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_ready && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_desc;
        end
    end

endmodule

[rtl/core/utf8d_front.sv]
// ----------------------------------------------------------------------------
// utf8d_front
// byte classifier and sequence tracker, one byte per cycle while the queue has room
// ----------------------------------------------------------------------------
module utf8d_front
    import utf8d_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              s_tlast,
    output logic              push_valid,
    input  logic              push_ready,
    output desc_t             push_desc
);

    logic [1:0]      need_reg, need_next;
    logic [1:0]      gath_reg, gath_next;
    logic [CP_W-1:0] pcp_reg, pcp_next;

    logic            pending, is_cont, accept;
    logic [1:0]      ext_need, ext_gath;
    logic [CP_W-1:0] ext_pcp;
    desc_t           desc;

    assign pending  = (need_reg != 2'd0);
    assign is_cont  = (s_tdata[7:6] == 2'b10);
    assign ext_need = need_reg - 2'd1;
    assign ext_gath = gath_reg + 2'd1;
    assign ext_pcp  = {pcp_reg[CP_W-7:0], s_tdata[5:0]};

    always_comb begin
        need_next     = need_reg;
        gath_next     = gath_reg;
        pcp_next      = pcp_reg;
        desc.rep_cnt  = 2'd0;
        desc.has_tail = 1'b0;
        desc.tail_cp  = REPLACEMENT_CP;
        if (pending && is_cont) begin
            // continuation of an open sequence
            if (ext_need == 2'd0) begin
                desc.has_tail = 1'b1;
                desc.tail_cp  = ext_pcp;
                need_next     = 2'd0;
                gath_next     = 2'd0;
                pcp_next      = '0;
            end else if (s_tlast) begin
                desc.rep_cnt = ext_gath + 2'd1;
                need_next    = 2'd0;
                gath_next    = 2'd0;
                pcp_next     = '0;
            end else begin
                need_next = ext_need;
                gath_next = ext_gath;
                pcp_next  = ext_pcp;
            end
        end else begin
            // a broken sequence is flushed, then the byte is taken afresh
            if (pending) begin
                desc.rep_cnt = gath_reg + 2'd1;
            end
            need_next = 2'd0;
            gath_next = 2'd0;
            pcp_next  = '0;
            if (s_tdata[7] == 1'b0) begin
                desc.has_tail = 1'b1;
                desc.tail_cp  = CP_W'(s_tdata);
            end else if (s_tdata[7:5] == 3'b110 || s_tdata[7:4] == 4'b1110
                         || s_tdata[7:3] == 5'b11110) begin
                if (s_tlast) begin
                    desc.has_tail = 1'b1;
                end else if (s_tdata[7:5] == 3'b110) begin
                    need_next = 2'd1;
                    pcp_next  = CP_W'(s_tdata[4:0]);
                end else if (s_tdata[7:4] == 4'b1110) begin
                    need_next = 2'd2;
                    pcp_next  = CP_W'(s_tdata[3:0]);
                end else begin
                    need_next = 2'd3;
                    pcp_next  = CP_W'(s_tdata[2:0]);
                end
            end else begin
                // stray continuation or invalid lead
                desc.has_tail = 1'b1;
            end
        end
    end

    assign s_tready   = push_ready;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = s_tvalid && ((desc.rep_cnt != 2'd0) || desc.has_tail);
    assign push_desc  = desc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            need_reg <= 2'd0;
            gath_reg <= 2'd0;
            pcp_reg  <= '0;
        end else if (accept) begin
            need_reg <= need_next;
            gath_reg <= gath_next;
            pcp_reg  <= pcp_next;
        end
    end

endmodule

[rtl/core/utf8d_back.sv]
// ----------------------------------------------------------------------------
// utf8d_back
// expands queued descriptors into one result per cycle while m_tready is high
// ----------------------------------------------------------------------------
module utf8d_back
    import utf8d_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  desc_t               q_desc,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [CP_PAD_W-1:0] m_tdata,
    output logic                m_tlast
);

    logic            work_valid_reg, work_valid_next;
    logic [1:0]      rep_left_reg, rep_left_next;
    logic            tail_reg, tail_next;
    logic [CP_W-1:0] tail_cp_reg, tail_cp_next;
    logic            sent, is_last, take;

    assign is_last = (rep_left_reg == 2'd0) || ((rep_left_reg == 2'd1) && !tail_reg);
    assign sent    = m_tvalid && m_tready;
    assign q_ready = !work_valid_reg || (sent && is_last);
    assign take    = q_ready && q_valid;

    always_comb begin
        work_valid_next = work_valid_reg;
        rep_left_next   = rep_left_reg;
        tail_next       = tail_reg;
        tail_cp_next    = tail_cp_reg;
        if (take) begin
            work_valid_next = 1'b1;
            rep_left_next   = q_desc.rep_cnt;
            tail_next       = q_desc.has_tail;
            tail_cp_next    = q_desc.tail_cp;
        end else if (sent && is_last) begin
            work_valid_next = 1'b0;
        end else if (sent) begin
            rep_left_next = rep_left_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
        end else begin
            work_valid_reg <= work_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rep_left_reg <= rep_left_next;
        tail_reg     <= tail_next;
        tail_cp_reg  <= tail_cp_next;
    end

    assign m_tvalid = work_valid_reg;
    assign m_tlast  = is_last;
    assign m_tdata  = CP_PAD_W'((rep_left_reg != 2'd0) ? REPLACEMENT_CP : tail_cp_reg);

endmodule

[rtl/core/utf8d_checker.sv]
// ----------------------------------------------------------------------------
// utf8d_checker
// port-level assertions for the utf-8 stream decoder
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8d_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    logic in_busy;

    assign in_busy = s_tvalid && (s_tdata != 8'h00) && s_tlast;

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // only replacements precede the last result of a byte
    `ASSERT_IMPLY(a_nonlast_repl, aclk, aresetn, m_tvalid && !m_tlast, m_tdata == 24'h00FFFD)

    // input only backs up when results are waiting
    `ASSERT_IMPLY(a_stall_cause, aclk, aresetn, !s_tready, m_tvalid)

    // output channel is empty right after reset
    `ASSERT_IMPLY(a_reset_idle, aclk, aresetn, $past(!aresetn) || !in_busy && $past(!aresetn), !m_tvalid)

endmodule

bind utf8_stream_decoder_top utf8d_checker u_utf8d_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[sim/tb_utf8_stream_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_top
// self-checking bench for the utf-8 stream decoder
// ----------------------------------------------------------------------------
// the bench feeds bytes over the input stream and predicts every code point
// with its own decoder state. each result transaction is checked against the
// oldest prediction. stimulus starts with directed sequences: well-formed,
// truncated, stray and invalid bytes, and end of text in the middle of a
// sequence. random text follows under several idle and stall mixes, then a
// long receiver hold-off that fills the block, and a sender pause that
// drains it.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_top;
    import utf8d_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned MAX_PRINTS  = 30;
    localparam int unsigned RUNS_PER_BYTE = 4;

    // one predicted result transaction
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            run_last;
    } decoded_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [CP_PAD_W-1:0] m_tdata;
    logic                m_tlast;

    utf8_stream_decoder_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // decoder state kept by the bench
    logic [1:0]      seq_need      = '0;
    logic [1:0]      seq_gathered  = '0;
    logic [CP_W-1:0] seq_partial   = '0;
    int              byte_results  = 0;

    decoded_t expected_code_points[$];

    int cycle_count      = 0;
    int error_count      = 0;
    int bytes_sent       = 0;
    int eot_sent         = 0;
    int results_checked  = 0;
    int replacements     = 0;
    int max_queue_seen   = 0;
    int tx_idle_pct      = 0;
    int rx_stall_pct     = 0;
    int rx_hold_left     = 0;
    bit rx_hold_request  = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // append one code point for the current byte, at most four per byte
    function automatic void add_code_point(input logic [CP_W-1:0] cp);
        decoded_t item;
        item.code_point = cp;
        item.run_last   = 1'b0;
        if (byte_results < RUNS_PER_BYTE) begin
            expected_code_points.insert(expected_code_points.size(), item);
            byte_results++;
            if (cp == REPLACEMENT_CP) begin
                replacements++;
            end
        end
    endfunction

    // one u+fffd for the lead plus one per continuation already taken
    function automatic void add_replacements(input int count);
        for (int k = 0; k < count; k++) begin
            add_code_point(REPLACEMENT_CP);
        end
    endfunction

    function automatic void clear_sequence();
        seq_need     = '0;
        seq_gathered = '0;
        seq_partial  = '0;
    endfunction

    // predict the results of one accepted byte
    function automatic void decode_byte(input logic [7:0] b, input logic eot);
        bit done;
        done         = 1'b0;
        byte_results = 0;
        if (seq_need != 0) begin
            if (b[7:6] == 2'b10) begin
                // continuation extends the pending sequence
                seq_partial  = {seq_partial[CP_W-7:0], b[5:0]};
                seq_need     = seq_need - 2'd1;
                seq_gathered = seq_gathered + 2'd1;
                if (seq_need == 0) begin
                    add_code_point(seq_partial);
                    clear_sequence();
                end else if (eot) begin
                    add_replacements(1 + seq_gathered);
                    clear_sequence();
                end
                done = 1'b1;
            end else begin
                // sequence cut short, then the byte is decoded afresh
                add_replacements(1 + seq_gathered);
                clear_sequence();
            end
        end
        if (!done) begin
            if (b[7] == 1'b0) begin
                add_code_point({{(CP_W-8){1'b0}}, b});
            end else if (b[7:5] == 3'b110) begin
                seq_need    = 2'd1;
                seq_partial = {{(CP_W-5){1'b0}}, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                seq_need    = 2'd2;
                seq_partial = {{(CP_W-4){1'b0}}, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                seq_need    = 2'd3;
                seq_partial = {{(CP_W-3){1'b0}}, b[2:0]};
            end else begin
                // stray continuation or invalid lead
                add_code_point(REPLACEMENT_CP);
            end
            if (seq_need != 0 && eot) begin
                add_code_point(REPLACEMENT_CP);
                clear_sequence();
            end
        end
        if (byte_results > 0) begin
            expected_code_points[$].run_last = 1'b1;
        end
        if (expected_code_points.size() > max_queue_seen) begin
            max_queue_seen = expected_code_points.size();
        end
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offer one byte and wait until the transaction is accepted; tvalid stays
    // high afterwards so that back-to-back bytes follow without a gap in tvalid
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b, eot);
        bytes_sent++;
        if (eot) begin
            eot_sent++;
        end
    endtask

    // stop offering and wait until every predicted result has been checked
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_code_points.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // random stalls, or a held-off stretch while a hold is running
    always @(posedge aclk) begin
        m_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end

    // hold-off length counted here, started by a request from the tests
    always @(posedge aclk) begin
        if (rx_hold_request) begin
            rx_hold_request = 1'b0;
            rx_hold_left <= HOLD_CYCLES;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTS) begin
            $display("[%0d] mismatch: %s, got 0x%0h expected 0x%0h",
                     cycle_count, what, got, want);
        end
        error_count++;
    endtask

    // compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        decoded_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_code_points.size() == 0) begin
                report_mismatch("result with nothing expected", 32'(m_tdata), 32'd0);
            end else begin
                want = expected_code_points.pop_front();
                if (m_tdata !== {{(CP_PAD_W-CP_W){1'b0}}, want.code_point}) begin
                    report_mismatch("code point", 32'(m_tdata), 32'(want.code_point));
                end
                if (m_tlast !== want.run_last) begin
                    report_mismatch("last of run", 32'(m_tlast), 32'(want.run_last));
                end
                results_checked++;
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_code_points.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extremes, every sequence length and each malformed case
    task automatic test_directed_cases();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);                  // ascii on the final byte
        send_byte(8'hC2, 1'b0);                  // two-byte sequence
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);                  // three-byte sequence
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF7, 1'b0);                  // largest 21-bit value
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h80, 1'b0);                  // stray continuation
        send_byte(8'hFF, 1'b0);                  // invalid leads
        send_byte(8'hF8, 1'b0);
        send_byte(8'hE2, 1'b0);                  // cut short by ascii
        send_byte(8'h82, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hF0, 1'b0);                  // cut short by invalid lead
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF0, 1'b0);                  // text ends on a continuation
        send_byte(8'h90, 1'b1);
        send_byte(8'hC3, 1'b1);                  // text ends on a lead
        send_byte(8'hF4, 1'b0);                  // cut short by a final lead
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hC3, 1'b1);
        wait_drained();
    endtask

    // random text: mostly well-formed sequences, some broken ones and noise
    task automatic test_random_text(input int tx_pct, input int rx_pct,
                                    input int n_bytes);
        logic [7:0] seq_bytes[$];
        int         kind;
        int         seq_len;
        int         sent;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent         = 0;
        while (sent < n_bytes) begin
            seq_bytes.delete();
            kind = $urandom_range(99);
            if (kind < 20) begin
                seq_bytes.insert(seq_bytes.size(), {1'b0, 7'($urandom)});
            end else if (kind < 80) begin
                seq_len = $urandom_range(4, 2);
                case (seq_len)
                    2:       seq_bytes.insert(seq_bytes.size(), {3'b110, 5'($urandom)});
                    3:       seq_bytes.insert(seq_bytes.size(), {4'b1110, 4'($urandom)});
                    default: seq_bytes.insert(seq_bytes.size(), {5'b11110, 3'($urandom)});
                endcase
                // truncated sequences drop one or more continuations
                if (kind >= 65) begin
                    seq_len = $urandom_range(seq_len - 1, 1);
                end
                for (int k = 1; k < seq_len; k++) begin
                    seq_bytes.insert(seq_bytes.size(), {2'b10, 6'($urandom)});
                end
            end else if (kind < 88) begin
                seq_bytes.insert(seq_bytes.size(), {2'b10, 6'($urandom)});
            end else if (kind < 94) begin
                seq_bytes.insert(seq_bytes.size(), {5'b11111, 3'($urandom)});
            end else begin
                seq_bytes.insert(seq_bytes.size(), 8'($urandom));
            end
            foreach (seq_bytes[k]) begin
                send_byte(seq_bytes[k], $urandom_range(99) < 3);
            end
            sent += seq_bytes.size();
        end
        wait_drained();
    endtask

    // receiver holds off long enough for the block to fill and stall input
    task automatic test_backpressure_fill();
        rx_hold_request = 1'b1;
        test_random_text(0, 0, 40);
    endtask

    // sender pauses until every result is out, then resumes
    task automatic test_sender_pause_drain();
        test_random_text(18, 18, 15);
        test_random_text(0, 88, 15);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_random_text(0, 0, 90);
        test_random_text(88, 0, 90);
        test_random_text(0, 88, 90);
        test_random_text(18, 18, 90);
        test_backpressure_fill();
        test_sender_pause_drain();

        // catch any late or spurious results
        repeat (10) @(posedge aclk);
        if (expected_code_points.size() != 0) begin
            report_mismatch("results never arrived", 32'(expected_code_points.size()),
                            32'd0);
        end

        $display("covered %0d bytes (%0d end-of-text marks) and %0d results,",
                 bytes_sent, eot_sent, results_checked);
        $display("%0d of them replacements, up to %0d results in flight",
                 replacements, max_queue_seen);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
